@@ sv/jddm_pkg.sv @@
// Shared types and constants for the joystick differential drive mixer.
package jddm_pkg;

	typedef enum logic [2:0] {
		REG_FWD_CENTER  = 3'd0,
		REG_SIDE_CENTER = 3'd1,
		REG_FULL_SCALE  = 3'd2,
		REG_REV_LIMIT   = 3'd3,
		REG_DEADZONE    = 3'd4,
		REG_GAP         = 3'd5
	} cfg_idx_t;

	localparam logic [29:0] CORDIC_INV_GAIN = 30'd652032875;
	localparam logic [30:0] ANGLE_ONE = 31'h40000000;

	localparam logic [30:0] ATAN_TABLE [24] = '{
		31'd536870912, 31'd316933406, 31'd167458907, 31'd85004756,
		31'd42667331, 31'd21354465, 31'd10679838, 31'd5340245,
		31'd2670163, 31'd1335087, 31'd667544, 31'd333772,
		31'd166886, 31'd83443, 31'd41722, 31'd20861,
		31'd10430, 31'd5215, 31'd2608, 31'd1304,
		31'd652, 31'd326, 31'd163, 31'd81
	};

	typedef struct packed {
		logic neg;
		logic nz;
		logic ovf;
	} div_flags_t;

	typedef struct packed {
		logic signed [7:0] long_p;
		logic signed [7:0] lat_p;
		logic              rev;
		logic              x_nz;
		logic              x_neg;
		logic              y_pos;
		logic              y_neg;
	} mix_side_t;

endpackage

@@ sv/joystick_differential_drive_mixer.sv @@
// Top level of the joystick differential drive mixer.
// The mixer takes one pair of raw joystick samples per cycle while the pipeline advances and
// returns forward and sideways percent together with left and right wheel commands. Every
// transaction passes through centering (the numerator register and the divider input
// register), a row of AXIS_FRAC_BITS + 1 division cells that resolve one quotient bit each,
// scaling (the magnitude register and the CORDIC input register), a row of CORDIC_STAGES
// rotation cells and then gain correction, mixing, deadzone and straightening. The whole
// pipeline advances together, so it holds while a finished result is not taken at the output.
module joystick_differential_drive_mixer #(
	parameter int CORDIC_STAGES  = 16,
	parameter int AXIS_FRAC_BITS = 15
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic signed [15:0] raw_forward,
	input  logic signed [15:0] raw_sideways,
	output logic              out_valid,
	input  logic              out_ready,
	output logic signed [7:0] long_percent,
	output logic signed [7:0] lat_percent,
	output logic signed [7:0] left_percent,
	output logic signed [7:0] right_percent,
	input  logic              cfg_write,
	input  logic [2:0]        cfg_index,
	input  logic [14:0]       cfg_data
);

	localparam int F   = AXIS_FRAC_BITS;
	localparam int C   = CORDIC_STAGES;
	localparam int NW  = F + 18;
	localparam int CW  = F + 7;
	localparam int MW  = F + 5;
	localparam int NST = F + C + 11;

	localparam logic [F:0]      ONE     = {1'b1, {F{1'b0}}};
	localparam logic [MW-1:0]   FULL    = {1'b1, {(F+4){1'b0}}};
	localparam logic [F+7:0]    AX_HALF = (F+8)'(1) << (F-1);
	localparam logic [MW+6:0]   P_HALF  = (MW+7)'(1) << (F+3);

	logic [14:0] fwd_center_q;
	logic [14:0] side_center_q;
	logic [14:0] full_scale_q;
	logic [14:0] rev_limit_q;
	logic [6:0]  deadzone_q;
	logic [7:0]  gap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_center_q  <= 15'd13200;
			side_center_q <= 15'd13200;
			full_scale_q  <= 15'd13200;
			rev_limit_q   <= 15'd3277;
			deadzone_q    <= 7'd5;
			gap_q         <= 8'd5;
		end else if (cfg_write) begin
			unique case (jddm_pkg::cfg_idx_t'(cfg_index))
				jddm_pkg::REG_FWD_CENTER:  fwd_center_q  <= cfg_data;
				jddm_pkg::REG_SIDE_CENTER: side_center_q <= cfg_data;
				jddm_pkg::REG_FULL_SCALE:  full_scale_q  <= cfg_data;
				jddm_pkg::REG_REV_LIMIT:   rev_limit_q   <= cfg_data;
				jddm_pkg::REG_DEADZONE:    deadzone_q    <= cfg_data[6:0];
				jddm_pkg::REG_GAP:         gap_q         <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	logic           adv;
	logic [NST-1:0] vld_q;

	assign adv       = !out_valid || out_ready;
	assign in_ready  = adv;
	assign out_valid = vld_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NST-2:0], in_valid};
		end
	end

	logic [15:0]        divisor;
	logic               fs_zero;
	logic signed [15:0] raw_a [2];
	logic [14:0]        ctr_a [2];
	logic [F:0]         mag_s3 [2];
	logic               neg_s3 [2];
	logic signed [7:0]  pct_c [2];

	assign divisor  = {full_scale_q, 1'b0};
	assign fs_zero  = full_scale_q == 15'd0;
	assign raw_a[0] = raw_forward;
	assign raw_a[1] = raw_sideways;
	assign ctr_a[0] = fwd_center_q;
	assign ctr_a[1] = side_center_q;

	for (genvar a = 0; a < 2; a++) begin : g_axis
		logic [16:0]          cen;
		logic [15:0]          cabs;
		logic [NW-1:0]        num;
		logic [NW-1:0]        num_s1;
		jddm_pkg::div_flags_t flg_s1;
		logic [16:0]          upper;
		logic [15:0]          rem_c [F+2];
		logic [F:0]           low_c [F+2];
		logic [F:0]           quo_c [F+2];
		jddm_pkg::div_flags_t flg_c [F+2];
		logic [F:0]           mag;
		logic [F+7:0]         pprod;
		logic [7:0]           pmag;

		always_comb begin
			cen  = {raw_a[a][15], raw_a[a]} - {2'b00, ctr_a[a]};
			cabs = cen[16] ? 16'(-cen) : cen[15:0];
			num  = (NW'(cabs) << (F + 1)) + NW'(full_scale_q);
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				num_s1 <= num;
				flg_s1 <= '{neg: cen[16], nz: (cen != 17'd0), ovf: 1'b0};
			end
		end

		assign upper = num_s1[NW-1:F+1];

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_c[0] <= upper[15:0];
				low_c[0] <= num_s1[F:0];
				quo_c[0] <= '0;
				flg_c[0] <= '{neg: flg_s1.neg, nz: flg_s1.nz,
					ovf: (upper >= {1'b0, divisor})};
			end
		end

		for (genvar k = 0; k <= F; k++) begin : g_div
			jddm_div_cell #(
				.FRAC_BITS(F)
			) u_div_cell (
				.clk    (clk),
				.en     (adv),
				.divisor(divisor),
				.rem_i  (rem_c[k]),
				.low_i  (low_c[k]),
				.quo_i  (quo_c[k]),
				.flags_i(flg_c[k]),
				.rem_q  (rem_c[k+1]),
				.low_q  (low_c[k+1]),
				.quo_q  (quo_c[k+1]),
				.flags_q(flg_c[k+1])
			);
		end

		always_comb begin
			if (fs_zero) begin
				mag = flg_c[F+1].nz ? ONE : '0;
			end else if (flg_c[F+1].ovf || quo_c[F+1] > ONE) begin
				mag = ONE;
			end else begin
				mag = quo_c[F+1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				mag_s3[a] <= mag;
				neg_s3[a] <= flg_c[F+1].neg;
			end
		end

		always_comb begin
			pprod    = (F+8)'(mag_s3[a]) * (F+8)'(100) + AX_HALF;
			pmag     = {1'b0, pprod[F+6:F]};
			pct_c[a] = neg_s3[a] ? -$signed(pmag) : $signed(pmag);
		end
	end

	logic [F:0]          mx;
	logic [F:0]          my;
	logic                rev_cmp;
	jddm_pkg::mix_side_t side_c;

	logic signed [CW-1:0] cx_c [C+1];
	logic signed [CW-1:0] cy_c [C+1];
	logic signed [31:0]   cz_c [C+1];
	jddm_pkg::mix_side_t  cs_c [C+1];

	always_comb begin
		mx      = mag_s3[1];
		my      = mag_s3[0];
		rev_cmp = {mx, 15'b0} < (F+16)'({rev_limit_q, {F{1'b0}}});
		side_c.long_p = pct_c[0];
		side_c.lat_p  = pct_c[1];
		side_c.y_neg  = neg_s3[0] && (my != '0);
		side_c.y_pos  = !neg_s3[0] && (my != '0);
		side_c.x_nz   = mx != '0;
		side_c.x_neg  = neg_s3[1] && (mx != '0);
		side_c.rev    = rev_cmp && neg_s3[0] && (my != '0);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cx_c[0] <= CW'({my, 4'b0});
			cy_c[0] <= CW'({mx, 4'b0});
			cz_c[0] <= '0;
			cs_c[0] <= side_c;
		end
	end

	for (genvar k = 0; k < C; k++) begin : g_cordic
		jddm_cordic_cell #(
			.XY_W (CW),
			.SHIFT(k)
		) u_cordic_cell (
			.clk   (clk),
			.en    (adv),
			.x_i   (cx_c[k]),
			.y_i   (cy_c[k]),
			.z_i   (cz_c[k]),
			.side_i(cs_c[k]),
			.x_q   (cx_c[k+1]),
			.y_q   (cy_c[k+1]),
			.z_q   (cz_c[k+1]),
			.side_q(cs_c[k+1])
		);
	end

	logic [F+5:0]        xc;
	logic [30:0]         zc;
	logic [30:0]         frac;
	logic [F+35:0]       prod_x_s5;
	logic [30:0]         frac_s5;
	jddm_pkg::mix_side_t side_s5;

	always_comb begin
		xc = cx_c[C][CW-1] ? '0 : cx_c[C][CW-2:0];
		if (cz_c[C] < 32'sd0) begin
			zc = '0;
		end else if (cz_c[C] > $signed({1'b0, jddm_pkg::ANGLE_ONE})) begin
			zc = jddm_pkg::ANGLE_ONE;
		end else begin
			zc = cz_c[C][30:0];
		end
		frac = (cs_c[C].x_nz && !cs_c[C].y_pos) ? '0 : jddm_pkg::ANGLE_ONE - zc;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_x_s5 <= (F+36)'(xc) * (F+36)'(jddm_pkg::CORDIC_INV_GAIN);
			frac_s5   <= frac;
			side_s5   <= cs_c[C];
		end
	end

	logic [F+35:0]       rsum;
	logic [F+5:0]        mr;
	logic [MW-1:0]       mag_s6;
	logic [30:0]         frac_s6;
	jddm_pkg::mix_side_t side_s6;

	always_comb begin
		rsum = prod_x_s5 + (F+36)'(1 << 29);
		mr   = rsum[F+35:30];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s6  <= (mr > (F+6)'(FULL)) ? FULL : mr[MW-1:0];
			frac_s6 <= frac_s5;
			side_s6 <= side_s5;
		end
	end

	logic [MW+30:0]      prodi_s7;
	logic [MW+6:0]       m100_s7;
	jddm_pkg::mix_side_t side_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			prodi_s7 <= (MW+31)'(mag_s6) * (MW+31)'(frac_s6);
			m100_s7  <= (MW+7)'(mag_s6) * (MW+7)'(100);
			side_s7  <= side_s6;
		end
	end

	logic [MW+30:0]      isum;
	logic [MW+6:0]       osum;
	logic [MW-1:0]       inner_s8;
	logic [6:0]          outer_s8;
	jddm_pkg::mix_side_t side_s8;

	always_comb begin
		isum = prodi_s7 + (MW+31)'(1 << 29);
		osum = m100_s7 + P_HALF;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			inner_s8 <= isum[MW+29:30];
			outer_s8 <= osum[F+10:F+4];
			side_s8  <= side_s7;
		end
	end

	logic [MW+6:0]       isum2;
	logic [6:0]          inner_p_s9;
	logic [6:0]          outer_p_s9;
	jddm_pkg::mix_side_t side_s9;

	assign isum2 = (MW+7)'(inner_s8) * (MW+7)'(100) + P_HALF;

	always_ff @(posedge clk) begin
		if (adv) begin
			inner_p_s9 <= isum2[F+10:F+4];
			outer_p_s9 <= outer_s8;
			side_s9    <= side_s8;
		end
	end

	logic [6:0]        lm;
	logic [6:0]        rm;
	logic              dneg;
	logic signed [7:0] l0;
	logic signed [7:0] r0;
	logic signed [7:0] l1;
	logic signed [7:0] r1;
	logic signed [7:0] l2;
	logic signed [7:0] r2;
	logic [7:0]        la;
	logic [7:0]        ra;
	logic signed [8:0] d;
	logic [8:0]        da;

	always_comb begin
		lm   = side_s9.x_neg ? outer_p_s9 : inner_p_s9;
		rm   = side_s9.x_neg ? inner_p_s9 : outer_p_s9;
		dneg = !side_s9.x_nz && side_s9.y_neg;
		if (side_s9.rev) begin
			l0 = side_s9.long_p;
			r0 = side_s9.long_p;
		end else begin
			l0 = dneg ? -$signed({1'b0, lm}) : $signed({1'b0, lm});
			r0 = dneg ? -$signed({1'b0, rm}) : $signed({1'b0, rm});
		end
		la = l0[7] ? 8'(-l0) : 8'(l0);
		ra = r0[7] ? 8'(-r0) : 8'(r0);
		if (la < {1'b0, deadzone_q} && ra < {1'b0, deadzone_q}) begin
			l1 = '0;
			r1 = '0;
		end else begin
			l1 = l0;
			r1 = r0;
		end
		d  = {l1[7], l1} - {r1[7], r1};
		da = d[8] ? 9'(-d) : 9'(d);
		l2 = l1;
		r2 = r1;
		if (!side_s9.rev && da < {1'b0, gap_q}) begin
			if (l1 > 8'sd0 && r1 > 8'sd0) begin
				l2 = (l1 > r1) ? l1 : r1;
				r2 = (l1 > r1) ? l1 : r1;
			end else if (l1 < 8'sd0 && r1 < 8'sd0) begin
				l2 = (l1 < r1) ? l1 : r1;
				r2 = (l1 < r1) ? l1 : r1;
			end
		end
	end

	logic signed [7:0] long_s10;
	logic signed [7:0] lat_s10;
	logic signed [7:0] left_s10;
	logic signed [7:0] right_s10;

	always_ff @(posedge clk) begin
		if (adv) begin
			long_s10  <= side_s9.long_p;
			lat_s10   <= side_s9.lat_p;
			left_s10  <= l2;
			right_s10 <= r2;
		end
	end

	assign long_percent  = long_s10;
	assign lat_percent   = lat_s10;
	assign left_percent  = left_s10;
	assign right_percent = right_s10;

	a_wheel_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (left_percent >= -8'sd100 && left_percent <= 8'sd100 &&
			right_percent >= -8'sd100 && right_percent <= 8'sd100))
		else $error("Wheel command out of range.");

	a_valid_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(adv))
		else $error("Result appeared without the pipeline advancing.");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("Input stalled without a pending result transaction.");

endmodule

@@ sv/jddm_div_cell.sv @@
// One restoring division cell that resolves a single quotient bit per cycle while en is high.
module jddm_div_cell #(
	parameter int FRAC_BITS = 15
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic [15:0]              divisor,
	input  logic [15:0]              rem_i,
	input  logic [FRAC_BITS:0]       low_i,
	input  logic [FRAC_BITS:0]       quo_i,
	input  jddm_pkg::div_flags_t     flags_i,
	output logic [15:0]              rem_q,
	output logic [FRAC_BITS:0]       low_q,
	output logic [FRAC_BITS:0]       quo_q,
	output jddm_pkg::div_flags_t     flags_q
);

	logic [16:0] trial;
	logic [16:0] diff;
	logic        ge;

	always_comb begin
		trial = {rem_i, low_i[FRAC_BITS]};
		diff  = trial - {1'b0, divisor};
		ge    = trial >= {1'b0, divisor};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q   <= ge ? diff[15:0] : trial[15:0];
			low_q   <= {low_i[FRAC_BITS-1:0], 1'b0};
			quo_q   <= {quo_i[FRAC_BITS-1:0], ge};
			flags_q <= flags_i;
		end
	end

endmodule

@@ sv/jddm_cordic_cell.sv @@
// One CORDIC vectoring cell that performs a single micro-rotation per cycle while en is high.
module jddm_cordic_cell #(
	parameter int XY_W  = 22,
	parameter int SHIFT = 0
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [XY_W-1:0]   x_i,
	input  logic signed [XY_W-1:0]   y_i,
	input  logic signed [31:0]       z_i,
	input  jddm_pkg::mix_side_t      side_i,
	output logic signed [XY_W-1:0]   x_q,
	output logic signed [XY_W-1:0]   y_q,
	output logic signed [31:0]       z_q,
	output jddm_pkg::mix_side_t      side_q
);

	logic signed [XY_W-1:0] xs;
	logic signed [XY_W-1:0] ys;
	logic signed [31:0]     ang;

	always_comb begin
		xs  = x_i >>> SHIFT;
		ys  = y_i >>> SHIFT;
		ang = $signed({1'b0, jddm_pkg::ATAN_TABLE[SHIFT]});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (!y_i[XY_W-1]) begin
				x_q <= x_i + ys;
				y_q <= y_i - xs;
				z_q <= z_i + ang;
			end else begin
				x_q <= x_i - ys;
				y_q <= y_i + xs;
				z_q <= z_i - ang;
			end
			side_q <= side_i;
		end
	end

endmodule
